// ===== rtl/core/hblp_pkg.sv =====
// Types and constants shared by the header block line parser.
// No dependencies; every other rtl/core file refers to it by scoped name.
package hblp_pkg;

    localparam int BYTE_W = 8;
    localparam int CAP_W  = 7;
    localparam int IDX_W  = 6;
    localparam int OFF_W  = 12;
    localparam int CONS_W = 13;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd16;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        PH_LSTART,
        PH_INLINE,
        PH_CRLINE,
        PH_CRBLANK,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        RK_HEADER     = 2'd0,
        RK_END        = 2'd1,
        RK_INCOMPLETE = 2'd2,
        RK_ERROR      = 2'd3
    } result_kind_t;

    typedef enum logic [2:0] {
        EC_EMPTY_KEY = 3'd0,
        EC_NO_COLON  = 3'd1,
        EC_EMPTY_VAL = 3'd2,
        EC_NO_SPACE  = 3'd3,
        EC_BAD_CRLF  = 3'd4,
        EC_TOO_MANY  = 3'd5,
        EC_TOO_LONG  = 3'd6
    } error_code_t;

    typedef struct packed {
        result_kind_t      kind;
        error_code_t       err;
        logic [IDX_W-1:0]  idx;
        logic [OFF_W-1:0]  key_off;
        logic [OFF_W-1:0]  key_len;
        logic [OFF_W-1:0]  val_off;
        logic [OFF_W-1:0]  val_len;
        logic [CONS_W-1:0] consumed;
    } result_t;

    // What one byte produces: an optional main result, then an optional incomplete.
    typedef struct packed {
        logic    has_main;
        logic    has_inc;
        result_t main;
    } step_out_t;

endpackage

// ===== rtl/core/hblp_in_reg.sv =====
// Input register stage of the header block line parser.
// Uses hblp_pkg for the byte width.
module hblp_in_reg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hblp_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    input  logic                         take,
    output logic                         vld,
    output logic [hblp_pkg::BYTE_W-1:0]  data_byte,
    output logic                         eob
);

    logic                        vld_reg;
    logic                        vld_next;
    logic [hblp_pkg::BYTE_W-1:0] byte_reg;
    logic                        eob_reg;

    assign s_tready = !vld_reg || take;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_tready)
        begin
            vld_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // hold the word until the parser takes it
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
            eob_reg  <= s_tlast;
        end
    end

    assign vld       = vld_reg;
    assign data_byte = byte_reg;
    assign eob       = eob_reg;

endmodule

// ===== rtl/core/hblp_parse_core.sv =====
// Parse state and single-pass decode of one byte of a header block.
// Uses hblp_pkg for phase, result types and character constants.
module hblp_parse_core
#(
    parameter int MAX_BUFFER_BYTES = 4096,
    parameter int MAX_HEADERS      = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [hblp_pkg::CAP_W-1:0]   cfg_wr_data,
    input  logic [hblp_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         eob,
    input  logic                         go,
    output hblp_pkg::step_out_t          step_out
);

    localparam int PW   = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int HW   = $clog2(MAX_HEADERS + 1);
    localparam int CMPW = (HW > hblp_pkg::CAP_W) ? HW : hblp_pkg::CAP_W;
    localparam logic [PW-1:0]   POS_MAX = PW'(MAX_BUFFER_BYTES);
    localparam logic [CMPW-1:0] HDR_MAX = CMPW'(MAX_HEADERS);

    hblp_pkg::phase_t             phase_reg;
    hblp_pkg::phase_t             phase_next;
    logic [PW-1:0]                pos_reg;
    logic [PW-1:0]                pos_next;
    logic [PW-1:0]                lstart_reg;
    logic [PW-1:0]                lstart_next;
    logic [PW-1:0]                colon_reg;
    logic [PW-1:0]                colon_next;
    logic                         seen_reg;
    logic                         seen_next;
    logic                         space_reg;
    logic                         space_next;
    logic [HW-1:0]                count_reg;
    logic [HW-1:0]                count_next;
    logic [hblp_pkg::CAP_W-1:0]   cap_reg;

    logic                         is_cr;
    logic                         is_lf;
    logic [PW:0]                  cr_minus_colon;
    logic [PW:0]                  colon_plus1;
    logic [PW+1:0]                colon_plus2;
    logic [PW:0]                  pos_plus1;
    logic                         at_cap;
    logic                         err_hit;
    hblp_pkg::error_code_t        err_code;
    logic                         header;
    logic                         endblk;
    logic                         too_long;
    logic                         any_err;

    assign is_cr          = (data_byte == hblp_pkg::CH_CR);
    assign is_lf          = (data_byte == hblp_pkg::CH_LF);
    // CR sits one byte back; a borrow means the colon lies past the CR
    assign cr_minus_colon = {1'b0, pos_reg} - {{PW{1'b0}}, 1'b1} - {1'b0, colon_reg};
    assign colon_plus1    = {1'b0, colon_reg} + {{PW{1'b0}}, 1'b1};
    assign colon_plus2    = {2'b00, colon_reg} + (PW+2)'(2);
    assign pos_plus1      = {1'b0, pos_reg} + {{PW{1'b0}}, 1'b1};
    assign at_cap         = (CMPW'(count_reg) >= CMPW'(cap_reg))
                            || (CMPW'(count_reg) >= HDR_MAX);

    // decode: line checks in precedence order
    always_comb
    begin
        err_hit  = 1'b0;
        err_code = hblp_pkg::EC_EMPTY_KEY;
        header   = 1'b0;
        endblk   = 1'b0;
        unique case (phase_reg)
            hblp_pkg::PH_CRLINE:
            begin
                priority if (seen_reg && (colon_reg == lstart_reg))
                begin
                    err_hit  = 1'b1;
                    err_code = hblp_pkg::EC_EMPTY_KEY;
                end
                else if (!seen_reg)
                begin
                    err_hit  = 1'b1;
                    err_code = hblp_pkg::EC_NO_COLON;
                end
                else if (!cr_minus_colon[PW] && (cr_minus_colon[PW-1:0] <= PW'(2)))
                begin
                    err_hit  = 1'b1;
                    err_code = hblp_pkg::EC_EMPTY_VAL;
                end
                else if (!space_reg)
                begin
                    err_hit  = 1'b1;
                    err_code = hblp_pkg::EC_NO_SPACE;
                end
                else if (!is_lf)
                begin
                    err_hit  = 1'b1;
                    err_code = hblp_pkg::EC_BAD_CRLF;
                end
                else if (at_cap)
                begin
                    err_hit  = 1'b1;
                    err_code = hblp_pkg::EC_TOO_MANY;
                end
                else
                begin
                    header = 1'b1;
                end
            end
            hblp_pkg::PH_CRBLANK:
            begin
                if (!is_lf)
                begin
                    err_hit  = 1'b1;
                    err_code = hblp_pkg::EC_BAD_CRLF;
                end
                else
                begin
                    endblk = 1'b1;
                end
            end
            default:
            begin
                err_hit = 1'b0;
            end
        endcase
    end

    assign too_long = (phase_reg != hblp_pkg::PH_DONE) && !err_hit && (pos_reg >= POS_MAX);
    assign any_err  = err_hit || too_long;

    // results of this byte
    always_comb
    begin
        step_out      = '0;
        step_out.main.kind = hblp_pkg::RK_HEADER;
        step_out.main.err  = hblp_pkg::EC_EMPTY_KEY;
        if (phase_reg != hblp_pkg::PH_DONE)
        begin
            if (any_err)
            begin
                step_out.has_main  = 1'b1;
                step_out.main.kind = hblp_pkg::RK_ERROR;
                step_out.main.err  = too_long ? hblp_pkg::EC_TOO_LONG : err_code;
            end
            else if (header)
            begin
                step_out.has_main     = 1'b1;
                step_out.main.kind    = hblp_pkg::RK_HEADER;
                step_out.main.idx     = hblp_pkg::IDX_W'(count_reg);
                step_out.main.key_off = hblp_pkg::OFF_W'(lstart_reg);
                step_out.main.key_len = hblp_pkg::OFF_W'(colon_reg - lstart_reg);
                step_out.main.val_off = hblp_pkg::OFF_W'(colon_plus2);
                step_out.main.val_len = hblp_pkg::OFF_W'(cr_minus_colon - (PW+1)'(2));
            end
            else if (endblk)
            begin
                step_out.has_main      = 1'b1;
                step_out.main.kind     = hblp_pkg::RK_END;
                step_out.main.consumed = hblp_pkg::CONS_W'(pos_plus1);
            end
            step_out.has_inc = eob && !any_err && !endblk;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            hblp_pkg::PH_LSTART:
            begin
                phase_next = is_cr ? hblp_pkg::PH_CRBLANK : hblp_pkg::PH_INLINE;
            end
            hblp_pkg::PH_INLINE:
            begin
                phase_next = is_cr ? hblp_pkg::PH_CRLINE : hblp_pkg::PH_INLINE;
            end
            hblp_pkg::PH_CRLINE:
            begin
                phase_next = hblp_pkg::PH_LSTART;
            end
            hblp_pkg::PH_CRBLANK:
            begin
                phase_next = hblp_pkg::PH_DONE;
            end
            hblp_pkg::PH_DONE:
            begin
                phase_next = hblp_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = hblp_pkg::PH_DONE;
            end
        endcase
        if (any_err || endblk)
        begin
            phase_next = hblp_pkg::PH_DONE;
        end
        if (eob)
        begin
            phase_next = hblp_pkg::PH_LSTART;
        end
    end

    // line bookkeeping
    always_comb
    begin
        pos_next    = pos_reg;
        lstart_next = lstart_reg;
        colon_next  = colon_reg;
        seen_next   = seen_reg;
        space_next  = space_reg;
        count_next  = count_reg;
        if ((phase_reg == hblp_pkg::PH_LSTART || phase_reg == hblp_pkg::PH_INLINE) && !is_cr)
        begin
            if ((data_byte == hblp_pkg::CH_COLON) && !seen_reg)
            begin
                seen_next  = 1'b1;
                colon_next = pos_reg;
            end
            else if (seen_reg && ({1'b0, pos_reg} == colon_plus1)
                     && (data_byte == hblp_pkg::CH_SPACE))
            begin
                space_next = 1'b1;
            end
        end
        if (header && !too_long)
        begin
            count_next  = count_reg + {{(HW-1){1'b0}}, 1'b1};
            lstart_next = PW'(pos_plus1);
            seen_next   = 1'b0;
            space_next  = 1'b0;
            colon_next  = '0;
        end
        if (phase_reg != hblp_pkg::PH_DONE && pos_reg < POS_MAX)
        begin
            pos_next = PW'(pos_plus1);
        end
        if (eob)
        begin
            pos_next    = '0;
            lstart_next = '0;
            colon_next  = '0;
            seen_next   = 1'b0;
            space_next  = 1'b0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hblp_pkg::PH_LSTART;
            pos_reg    <= '0;
            lstart_reg <= '0;
            colon_reg  <= '0;
            seen_reg   <= 1'b0;
            space_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (go)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            lstart_reg <= lstart_next;
            colon_reg  <= colon_next;
            seen_reg   <= seen_next;
            space_reg  <= space_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= hblp_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== rtl/core/hblp_out_stage.sv =====
// Result register of the header block line parser; plays out up to two words per byte.
// Uses hblp_pkg for the result types.
module hblp_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hblp_pkg::step_out_t  step_out,
    input  logic                 load,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output hblp_pkg::result_t    item,
    output logic                 item_last
);

    logic                busy_reg;
    logic                busy_next;
    logic                pend_reg;
    logic                pend_next;
    logic                last_reg;
    logic                last_next;
    hblp_pkg::result_t   cur_reg;
    hblp_pkg::result_t   cur_next;
    hblp_pkg::result_t   inc_item;
    logic                taken;

    always_comb
    begin
        inc_item      = '0;
        inc_item.kind = hblp_pkg::RK_INCOMPLETE;
        inc_item.err  = hblp_pkg::EC_EMPTY_KEY;
    end

    assign taken    = busy_reg && m_tready;
    assign can_load = !busy_reg || (taken && !pend_reg);

    always_comb
    begin
        busy_next = busy_reg;
        pend_next = pend_reg;
        last_next = last_reg;
        cur_next  = cur_reg;
        if (load && (step_out.has_main || step_out.has_inc))
        begin
            busy_next = 1'b1;
            if (step_out.has_main)
            begin
                cur_next  = step_out.main;
                last_next = !step_out.has_inc;
                pend_next = step_out.has_inc;
            end
            else
            begin
                cur_next  = inc_item;
                last_next = 1'b1;
                pend_next = 1'b0;
            end
        end
        else if (taken)
        begin
            // advance to the trailing incomplete word, or drop out
            if (pend_reg)
            begin
                cur_next  = inc_item;
                last_next = 1'b1;
                pend_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        last_reg <= last_next;
    end

    assign m_tvalid  = busy_reg;
    assign item      = cur_reg;
    assign item_last = last_reg;

endmodule

// ===== rtl/core/header_block_line_parser.sv =====
// Top level of the header block line parser: input register, parse core, result register.
// Depends on hblp_pkg, hblp_in_reg, hblp_parse_core and hblp_out_stage.
//
//   channel  | dir | payload                                      | notes
//   ---------+-----+----------------------------------------------+---------------------------
//   s_*      | in  | tdata = data_byte, tlast = end_of_buffer     | one buffer byte per word
//   m_*      | out | tuser = result_kind, tdata = result fields,  | up to two words per byte
//            |     | tlast = last_of_run                          |
//   cfg_*    | in  | header_capacity (7 bits)                     | write when idle, reset 16
//
// Cycles: one byte is accepted per clock while s_tready is high. A byte is decoded in the
// cycle after it is registered; its first result word enters the result register (m_*) when
// the byte is taken. A byte that closes a header line and also ends the buffer gives two
// words and holds the result register until both are taken; every other byte gives at most
// one word. Reset clears the parse state and sets the capacity to 16. A stall on m_tready
// holds the result register and drops s_tready while the held input byte yields a word.
module header_block_line_parser
#(
    parameter int MAX_BUFFER_BYTES = 4096,
    parameter int MAX_HEADERS      = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,     // header_capacity

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // [7:0] data_byte
    input  logic        s_tlast,         // end_of_buffer

    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] error_code, [8:3] header_index, [20:9] key_offset, [32:21] key_length,
    // [44:33] value_offset, [56:45] value_length, [69:57] consumed_length, [71:70] zero
    output logic [71:0] m_tdata,
    output logic [1:0]  m_tuser,         // [1:0] result_kind
    output logic        m_tlast          // last_of_run
);

    logic                        in_vld;
    logic [hblp_pkg::BYTE_W-1:0] in_byte;
    logic                        in_eob;
    logic                        go;
    logic                        can_load;
    hblp_pkg::step_out_t         step_out;
    hblp_pkg::result_t           item;

    // A byte that yields no word passes even while the result register is full.
    assign go = in_vld && (can_load || !(step_out.has_main || step_out.has_inc));

    hblp_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .take      (go),
        .vld       (in_vld),
        .data_byte (in_byte),
        .eob       (in_eob)
    );

    hblp_parse_core
    #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
        .MAX_HEADERS      (MAX_HEADERS)
    )
    u_parse_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .data_byte   (in_byte),
        .eob         (in_eob),
        .go          (go),
        .step_out    (step_out)
    );

    hblp_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_out  (step_out),
        .load      (go),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .item      (item),
        .item_last (m_tlast)
    );

    // pack the result word, first field in the lowest bits
    assign m_tdata = {2'b00, item.consumed, item.val_len, item.val_off,
                      item.key_len, item.key_off, item.idx, item.err};
    assign m_tuser = item.kind;

endmodule
